// File: rtl/aes128_ctr_stream_cipher_core_macros.svh
// assertion macros for the aes counter-mode core
`ifndef AES128_CTR_STREAM_CIPHER_CORE_MACROS_SVH
`define AES128_CTR_STREAM_CIPHER_CORE_MACROS_SVH

// property that must hold at every edge out of reset
`define ACC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// implication checked in the cycle after its antecedent
`define ACC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/acc_pkg.sv
// types, s-box table and round helpers for the aes counter-mode core
package acc_pkg;

    typedef struct packed {
        logic [7:0]  data_byte;
        logic        first_byte;
        logic        last_byte;
        logic [63:0] iv_high;
        logic [63:0] iv_low;
    } t_in_word;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_last;
    } t_out_word;

    typedef enum logic [0:0] {
        REG_KEY_HIGH = 1'b0,
        REG_KEY_LOW  = 1'b1
    } t_reg_index;

    localparam int unsigned NumRounds = 10;

    // control from sequencer to round unit
    typedef struct packed {
        logic start;
        logic step;
    } t_round_ctrl;

    function automatic logic [7:0] sbox(input logic [7:0] x);
        logic [7:0] r;
        case (x)
            8'h00: r=8'h63; 8'h01: r=8'h7c; 8'h02: r=8'h77; 8'h03: r=8'h7b;
            8'h04: r=8'hf2; 8'h05: r=8'h6b; 8'h06: r=8'h6f; 8'h07: r=8'hc5;
            8'h08: r=8'h30; 8'h09: r=8'h01; 8'h0a: r=8'h67; 8'h0b: r=8'h2b;
            8'h0c: r=8'hfe; 8'h0d: r=8'hd7; 8'h0e: r=8'hab; 8'h0f: r=8'h76;
            8'h10: r=8'hca; 8'h11: r=8'h82; 8'h12: r=8'hc9; 8'h13: r=8'h7d;
            8'h14: r=8'hfa; 8'h15: r=8'h59; 8'h16: r=8'h47; 8'h17: r=8'hf0;
            8'h18: r=8'had; 8'h19: r=8'hd4; 8'h1a: r=8'ha2; 8'h1b: r=8'haf;
            8'h1c: r=8'h9c; 8'h1d: r=8'ha4; 8'h1e: r=8'h72; 8'h1f: r=8'hc0;
            8'h20: r=8'hb7; 8'h21: r=8'hfd; 8'h22: r=8'h93; 8'h23: r=8'h26;
            8'h24: r=8'h36; 8'h25: r=8'h3f; 8'h26: r=8'hf7; 8'h27: r=8'hcc;
            8'h28: r=8'h34; 8'h29: r=8'ha5; 8'h2a: r=8'he5; 8'h2b: r=8'hf1;
            8'h2c: r=8'h71; 8'h2d: r=8'hd8; 8'h2e: r=8'h31; 8'h2f: r=8'h15;
            8'h30: r=8'h04; 8'h31: r=8'hc7; 8'h32: r=8'h23; 8'h33: r=8'hc3;
            8'h34: r=8'h18; 8'h35: r=8'h96; 8'h36: r=8'h05; 8'h37: r=8'h9a;
            8'h38: r=8'h07; 8'h39: r=8'h12; 8'h3a: r=8'h80; 8'h3b: r=8'he2;
            8'h3c: r=8'heb; 8'h3d: r=8'h27; 8'h3e: r=8'hb2; 8'h3f: r=8'h75;
            8'h40: r=8'h09; 8'h41: r=8'h83; 8'h42: r=8'h2c; 8'h43: r=8'h1a;
            8'h44: r=8'h1b; 8'h45: r=8'h6e; 8'h46: r=8'h5a; 8'h47: r=8'ha0;
            8'h48: r=8'h52; 8'h49: r=8'h3b; 8'h4a: r=8'hd6; 8'h4b: r=8'hb3;
            8'h4c: r=8'h29; 8'h4d: r=8'he3; 8'h4e: r=8'h2f; 8'h4f: r=8'h84;
            8'h50: r=8'h53; 8'h51: r=8'hd1; 8'h52: r=8'h00; 8'h53: r=8'hed;
            8'h54: r=8'h20; 8'h55: r=8'hfc; 8'h56: r=8'hb1; 8'h57: r=8'h5b;
            8'h58: r=8'h6a; 8'h59: r=8'hcb; 8'h5a: r=8'hbe; 8'h5b: r=8'h39;
            8'h5c: r=8'h4a; 8'h5d: r=8'h4c; 8'h5e: r=8'h58; 8'h5f: r=8'hcf;
            8'h60: r=8'hd0; 8'h61: r=8'hef; 8'h62: r=8'haa; 8'h63: r=8'hfb;
            8'h64: r=8'h43; 8'h65: r=8'h4d; 8'h66: r=8'h33; 8'h67: r=8'h85;
            8'h68: r=8'h45; 8'h69: r=8'hf9; 8'h6a: r=8'h02; 8'h6b: r=8'h7f;
            8'h6c: r=8'h50; 8'h6d: r=8'h3c; 8'h6e: r=8'h9f; 8'h6f: r=8'ha8;
            8'h70: r=8'h51; 8'h71: r=8'ha3; 8'h72: r=8'h40; 8'h73: r=8'h8f;
            8'h74: r=8'h92; 8'h75: r=8'h9d; 8'h76: r=8'h38; 8'h77: r=8'hf5;
            8'h78: r=8'hbc; 8'h79: r=8'hb6; 8'h7a: r=8'hda; 8'h7b: r=8'h21;
            8'h7c: r=8'h10; 8'h7d: r=8'hff; 8'h7e: r=8'hf3; 8'h7f: r=8'hd2;
            8'h80: r=8'hcd; 8'h81: r=8'h0c; 8'h82: r=8'h13; 8'h83: r=8'hec;
            8'h84: r=8'h5f; 8'h85: r=8'h97; 8'h86: r=8'h44; 8'h87: r=8'h17;
            8'h88: r=8'hc4; 8'h89: r=8'ha7; 8'h8a: r=8'h7e; 8'h8b: r=8'h3d;
            8'h8c: r=8'h64; 8'h8d: r=8'h5d; 8'h8e: r=8'h19; 8'h8f: r=8'h73;
            8'h90: r=8'h60; 8'h91: r=8'h81; 8'h92: r=8'h4f; 8'h93: r=8'hdc;
            8'h94: r=8'h22; 8'h95: r=8'h2a; 8'h96: r=8'h90; 8'h97: r=8'h88;
            8'h98: r=8'h46; 8'h99: r=8'hee; 8'h9a: r=8'hb8; 8'h9b: r=8'h14;
            8'h9c: r=8'hde; 8'h9d: r=8'h5e; 8'h9e: r=8'h0b; 8'h9f: r=8'hdb;
            8'ha0: r=8'he0; 8'ha1: r=8'h32; 8'ha2: r=8'h3a; 8'ha3: r=8'h0a;
            8'ha4: r=8'h49; 8'ha5: r=8'h06; 8'ha6: r=8'h24; 8'ha7: r=8'h5c;
            8'ha8: r=8'hc2; 8'ha9: r=8'hd3; 8'haa: r=8'hac; 8'hab: r=8'h62;
            8'hac: r=8'h91; 8'had: r=8'h95; 8'hae: r=8'he4; 8'haf: r=8'h79;
            8'hb0: r=8'he7; 8'hb1: r=8'hc8; 8'hb2: r=8'h37; 8'hb3: r=8'h6d;
            8'hb4: r=8'h8d; 8'hb5: r=8'hd5; 8'hb6: r=8'h4e; 8'hb7: r=8'ha9;
            8'hb8: r=8'h6c; 8'hb9: r=8'h56; 8'hba: r=8'hf4; 8'hbb: r=8'hea;
            8'hbc: r=8'h65; 8'hbd: r=8'h7a; 8'hbe: r=8'hae; 8'hbf: r=8'h08;
            8'hc0: r=8'hba; 8'hc1: r=8'h78; 8'hc2: r=8'h25; 8'hc3: r=8'h2e;
            8'hc4: r=8'h1c; 8'hc5: r=8'ha6; 8'hc6: r=8'hb4; 8'hc7: r=8'hc6;
            8'hc8: r=8'he8; 8'hc9: r=8'hdd; 8'hca: r=8'h74; 8'hcb: r=8'h1f;
            8'hcc: r=8'h4b; 8'hcd: r=8'hbd; 8'hce: r=8'h8b; 8'hcf: r=8'h8a;
            8'hd0: r=8'h70; 8'hd1: r=8'h3e; 8'hd2: r=8'hb5; 8'hd3: r=8'h66;
            8'hd4: r=8'h48; 8'hd5: r=8'h03; 8'hd6: r=8'hf6; 8'hd7: r=8'h0e;
            8'hd8: r=8'h61; 8'hd9: r=8'h35; 8'hda: r=8'h57; 8'hdb: r=8'hb9;
            8'hdc: r=8'h86; 8'hdd: r=8'hc1; 8'hde: r=8'h1d; 8'hdf: r=8'h9e;
            8'he0: r=8'he1; 8'he1: r=8'hf8; 8'he2: r=8'h98; 8'he3: r=8'h11;
            8'he4: r=8'h69; 8'he5: r=8'hd9; 8'he6: r=8'h8e; 8'he7: r=8'h94;
            8'he8: r=8'h9b; 8'he9: r=8'h1e; 8'hea: r=8'h87; 8'heb: r=8'he9;
            8'hec: r=8'hce; 8'hed: r=8'h55; 8'hee: r=8'h28; 8'hef: r=8'hdf;
            8'hf0: r=8'h8c; 8'hf1: r=8'ha1; 8'hf2: r=8'h89; 8'hf3: r=8'h0d;
            8'hf4: r=8'hbf; 8'hf5: r=8'he6; 8'hf6: r=8'h42; 8'hf7: r=8'h68;
            8'hf8: r=8'h41; 8'hf9: r=8'h99; 8'hfa: r=8'h2d; 8'hfb: r=8'h0f;
            8'hfc: r=8'hb0; 8'hfd: r=8'h54; 8'hfe: r=8'hbb; 8'hff: r=8'h16;
            default: r = 8'h00;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] xtime(input logic [7:0] x);
        return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
    endfunction

endpackage

// File: rtl/acc_round_unit.sv
// shared aes-128 round unit with on-the-fly key expansion, one round a step
module acc_round_unit (
    input  logic                  i_clk,
    input  acc_pkg::t_round_ctrl  i_ctrl,
    input  logic                  i_last_round,
    input  logic [127:0]          i_key,
    input  logic [127:0]          i_block,
    output logic [127:0]          o_state
);

    logic [127:0] r_state;
    logic [127:0] r_rkey;
    logic [7:0]   r_rcon;
    logic [127:0] n_state;
    logic [127:0] n_rkey;
    logic [127:0] sub_shift;
    logic [127:0] mixed;
    logic [31:0]  rot_sub;

    // byte k of the block sits at bits 127-8k
    function automatic logic [7:0] get_byte(input logic [127:0] v, input int k);
        return v[127 - 8*k -: 8];
    endfunction

    // sub bytes and shift rows, byte (row,col) at col*4+row
    always_comb begin
        sub_shift = '0;
        for (int c = 0; c < 4; c++) begin
            for (int i = 0; i < 4; i++) begin
                sub_shift[127 - 8*(c*4+i) -: 8] =
                    acc_pkg::sbox(get_byte(r_state, ((c + i) % 4) * 4 + i));
            end
        end
    end

    // mix columns
    always_comb begin
        logic [7:0] a0, a1, a2, a3, all;
        mixed = '0;
        for (int c = 0; c < 4; c++) begin
            a0  = get_byte(sub_shift, c*4);
            a1  = get_byte(sub_shift, c*4+1);
            a2  = get_byte(sub_shift, c*4+2);
            a3  = get_byte(sub_shift, c*4+3);
            all = a0 ^ a1 ^ a2 ^ a3;
            mixed[127 - 8*(c*4)   -: 8] = a0 ^ all ^ acc_pkg::xtime(a0 ^ a1);
            mixed[127 - 8*(c*4+1) -: 8] = a1 ^ all ^ acc_pkg::xtime(a1 ^ a2);
            mixed[127 - 8*(c*4+2) -: 8] = a2 ^ all ^ acc_pkg::xtime(a2 ^ a3);
            mixed[127 - 8*(c*4+3) -: 8] = a3 ^ all ^ acc_pkg::xtime(a3 ^ a0);
        end
    end

    // next round key from the current one, and the next round state
    always_comb begin
        rot_sub = {acc_pkg::sbox(r_rkey[23:16]) ^ r_rcon, acc_pkg::sbox(r_rkey[15:8]),
                   acc_pkg::sbox(r_rkey[7:0]), acc_pkg::sbox(r_rkey[31:24])};
        n_rkey[127:96] = r_rkey[127:96] ^ rot_sub;
        n_rkey[95:64]  = r_rkey[95:64] ^ n_rkey[127:96];
        n_rkey[63:32]  = r_rkey[63:32] ^ n_rkey[95:64];
        n_rkey[31:0]   = r_rkey[31:0] ^ n_rkey[63:32];
        n_state = (i_last_round ? sub_shift : mixed) ^ n_rkey;
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.start) begin
            r_state <= i_block ^ i_key;
            r_rkey  <= i_key;
            r_rcon  <= 8'h01;
        end else if (i_ctrl.step) begin
            r_state <= n_state;
            r_rkey  <= n_rkey;
            r_rcon  <= acc_pkg::xtime(r_rcon);
        end
    end

    assign o_state = r_state;

endmodule

// File: rtl/aes128_ctr_stream_cipher_core.sv
// top level of the aes-128 counter-mode stream cipher core
//
//  channel | direction | handshake            | payload
//  in      | input     | i_in_valid/o_in_ready | acc_pkg::t_in_word
//  out     | output    | o_out_valid/i_out_ready | acc_pkg::t_out_word
//  cfg     | input     | i_cfg_we             | i_cfg_index, i_cfg_data
//
// a word that starts a new block (first byte or block position zero) goes through
// load, ten rounds of the shared round unit, then the result register; other words go
// straight to the result register. the input is held off while a block is in the round
// unit and while a result waits to be taken. reset clears key, counter, position and
// handshake state; keystream bytes are written before they are read and are not cleared.
`include "aes128_ctr_stream_cipher_core_macros.svh"

module aes128_ctr_stream_cipher_core (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  acc_pkg::t_in_word    i_in,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output acc_pkg::t_out_word   o_out,
    input  logic                 i_cfg_we,
    input  logic [0:0]           i_cfg_index,
    input  logic [63:0]          i_cfg_data
);

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_ROUND = 3'b010,
        ST_OUT   = 3'b100
    } t_state;

    t_state       r_state, n_state;
    logic [63:0]  r_key_high, r_key_low;
    logic [127:0] r_counter, n_counter;
    logic [3:0]   r_pos;
    logic [127:0] r_ks;
    logic [3:0]   r_round;
    logic [7:0]   r_data;
    logic         r_last;
    logic         r_out_valid;
    logic [7:0]   r_out_byte;
    logic         r_out_last;
    logic [127:0] block_state;
    acc_pkg::t_round_ctrl ctrl;
    logic         accept;
    logic         need_block;

    assign o_in_ready = (r_state == ST_IDLE) && !r_out_valid;
    assign accept     = i_in_valid && o_in_ready;
    assign need_block = i_in.first_byte || (r_pos == 4'd0);
    assign n_counter  = i_in.first_byte ? {i_in.iv_high, i_in.iv_low} : r_counter;

    assign ctrl.start = accept && need_block;
    assign ctrl.step  = (r_state == ST_ROUND);

    acc_round_unit u_round (
        .i_clk        (i_clk),
        .i_ctrl       (ctrl),
        .i_last_round (r_round == 4'(acc_pkg::NumRounds)),
        .i_key        ({r_key_high, r_key_low}),
        .i_block      (n_counter),
        .o_state      (block_state)
    );

    // key registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_high <= '0;
            r_key_low  <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                acc_pkg::REG_KEY_HIGH: r_key_high <= i_cfg_data;
                acc_pkg::REG_KEY_LOW:  r_key_low  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:  if (accept && need_block) n_state = ST_ROUND;
            ST_ROUND: if (r_round == 4'(acc_pkg::NumRounds)) n_state = ST_OUT;
            ST_OUT:   n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_counter   <= '0;
            r_pos       <= '0;
            r_round     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_out_valid && i_out_ready) r_out_valid <= 1'b0;
            if (accept) begin
                r_data <= i_in.data_byte;
                r_last <= i_in.last_byte;
                r_pos  <= i_in.last_byte ? 4'd0 : ((need_block ? 4'd0 : r_pos) + 4'd1);
                if (need_block) begin
                    r_counter <= n_counter + 128'd1;
                    r_round   <= 4'd1;
                end else begin
                    r_out_valid <= 1'b1;
                    r_out_byte  <= i_in.data_byte ^ r_ks[127 - 8*r_pos -: 8];
                    r_out_last  <= i_in.last_byte;
                end
            end
            if (r_state == ST_ROUND) r_round <= r_round + 4'd1;
            // new block finished: keep it and emit byte zero
            if (r_state == ST_OUT) begin
                r_ks        <= block_state;
                r_out_valid <= 1'b1;
                r_out_byte  <= r_data ^ block_state[127:120];
                r_out_last  <= r_last;
            end
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_out.out_byte    = r_out_byte;
    assign o_out.out_last    = r_out_last;

    `ACC_ASSERT(a_ready_idle, !(o_in_ready && (r_state != ST_IDLE)), "ready outside idle")
    `ACC_ASSERT_NEXT(a_round_done, (r_state == ST_OUT), o_out_valid, "block result not shown")
    `ACC_ASSERT_NEXT(a_out_hold, (o_out_valid && !i_out_ready), $stable(o_out) && o_out_valid,
        "stalled result changed")

endmodule

// File: tb/aes128_ctr_stream_cipher_core_test.sv
// testbench for the aes-128 counter-mode stream cipher core
`timescale 1ns / 100ps

module aes128_ctr_stream_cipher_core_test;

    localparam int unsigned WatchdogLimit = 20000;
    localparam int unsigned DrainCycles = 40;

    logic i_clk;
    logic i_rst_n;
    logic i_in_valid;
    logic o_in_ready;
    acc_pkg::t_in_word i_in;
    logic o_out_valid;
    logic i_out_ready;
    acc_pkg::t_out_word o_out;
    logic i_cfg_we;
    logic [0:0] i_cfg_index;
    logic [63:0] i_cfg_data;

    aes128_ctr_stream_cipher_core i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready), .i_in(i_in),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready), .o_out(o_out),
        .i_cfg_we(i_cfg_we), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    // clock
    always begin
        i_clk = 1'b1;
        #6;
        i_clk = 1'b0;
        #6;
    end

    // predictor state
    logic [127:0] cipher_key;
    logic [127:0] counter_value;
    logic [7:0] keystream [16];
    logic [3:0] block_pos;

    acc_pkg::t_in_word pending_words[$];
    acc_pkg::t_out_word expected_words[$];
    int unsigned mismatch_count;
    int unsigned stall_cycles;
    bit idle_enable;
    bit run_done;

    // lookup table for the predictor, built from the field inverse and affine map
    logic [7:0] subst [256];

    function automatic logic [7:0] gf_mult(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] p;
        p = 8'h00;
        for (int i = 0; i < 8; i++) begin
            if (b[i]) p ^= a;
            a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
        end
        return p;
    endfunction

    task automatic build_subst();
        logic [7:0] inv;
        logic [7:0] s;
        for (int x = 0; x < 256; x++) begin
            inv = 8'h00;
            for (int y = 1; y < 256; y++)
                if (gf_mult(x[7:0], y[7:0]) == 8'h01) inv = y[7:0];
            s = inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]} ^ {inv[4:0], inv[7:5]}
                ^ {inv[3:0], inv[7:4]} ^ 8'h63;
            subst[x] = s;
        end
    endtask

    function automatic logic [7:0] dbl(input logic [7:0] x);
        return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
    endfunction

    // one aes-128 block encryption, byte 0 in the top bits
    task automatic encrypt_block(input logic [127:0] key, input logic [127:0] blk);
        logic [7:0] rk [176];
        logic [7:0] st [16];
        logic [7:0] tt [16];
        logic [7:0] a, b, d, e, tmp, all;
        logic [7:0] rc;
        rc = 8'h01;
        for (int i = 0; i < 16; i++) begin
            rk[i] = key[127 - 8*i -: 8];
            st[i] = blk[127 - 8*i -: 8];
        end
        for (int i = 16; i < 176; i += 4) begin
            a = rk[i-4]; b = rk[i-3]; d = rk[i-2]; e = rk[i-1];
            if (i % 16 == 0) begin
                tmp = a;
                a = subst[b] ^ rc;
                b = subst[d];
                d = subst[e];
                e = subst[tmp];
                rc = dbl(rc);
            end
            rk[i] = rk[i-16] ^ a;
            rk[i+1] = rk[i-15] ^ b;
            rk[i+2] = rk[i-14] ^ d;
            rk[i+3] = rk[i-13] ^ e;
        end
        for (int i = 0; i < 16; i++) st[i] ^= rk[i];
        for (int r = 1; r <= 10; r++) begin
            for (int c = 0; c < 4; c++)
                for (int i = 0; i < 4; i++)
                    tt[c*4+i] = subst[st[((c+i)%4)*4+i]];
            if (r != 10) begin
                for (int c = 0; c < 4; c++) begin
                    a = tt[c*4]; b = tt[c*4+1]; d = tt[c*4+2]; e = tt[c*4+3];
                    all = a ^ b ^ d ^ e;
                    tt[c*4] = a ^ all ^ dbl(a ^ b);
                    tt[c*4+1] = b ^ all ^ dbl(b ^ d);
                    tt[c*4+2] = d ^ all ^ dbl(d ^ e);
                    tt[c*4+3] = e ^ all ^ dbl(e ^ a);
                end
            end
            for (int i = 0; i < 16; i++) st[i] = tt[i] ^ rk[r*16+i];
        end
        for (int i = 0; i < 16; i++) keystream[i] = st[i];
    endtask

    // expected result for one accepted word
    task automatic predict_cipher_byte(input acc_pkg::t_in_word w);
        acc_pkg::t_out_word res;
        if (w.first_byte) begin
            counter_value = {w.iv_high, w.iv_low};
            block_pos = 4'd0;
        end
        if (block_pos == 4'd0) begin
            encrypt_block(cipher_key, counter_value);
            counter_value = counter_value + 128'd1;
        end
        res.out_byte = w.data_byte ^ keystream[block_pos];
        res.out_last = w.last_byte;
        expected_words.push_back(res);
        block_pos = w.last_byte ? 4'd0 : block_pos + 4'd1;
    endtask

    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] want);
        $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
        mismatch_count++;
    endtask

    // input driver
    int unsigned in_gap;

    // acceptance flag sampled at the rising edge
    logic in_taken;
    always @(posedge i_clk) begin
        in_taken <= i_rst_n && i_in_valid && o_in_ready;
        if (i_rst_n && i_in_valid && o_in_ready) predict_cipher_byte(i_in);
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            in_gap = 0;
        end else if (i_in_valid && !in_taken) begin
            // hold until taken
        end else if (in_gap > 0) begin
            in_gap--;
            i_in_valid <= 1'b0;
        end else if (idle_enable && $urandom_range(0, 9) == 0) begin
            in_gap = $urandom_range(1, 8) - 1;
            i_in_valid <= 1'b0;
        end else if (pending_words.size() > 0) begin
            i_in <= pending_words.pop_front();
            i_in_valid <= 1'b1;
        end else begin
            i_in_valid <= 1'b0;
        end
    end

    // output stall driver
    int unsigned out_gap;
    always @(negedge i_clk) begin
        if (!i_rst_n || !idle_enable) begin
            i_out_ready <= 1'b1;
            out_gap = 0;
        end else if (out_gap > 0) begin
            out_gap--;
            i_out_ready <= 1'b0;
        end else if ($urandom_range(0, 7) == 0) begin
            out_gap = $urandom_range(1, 8) - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    // result monitor and watchdog
    acc_pkg::t_out_word want;
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
            if (o_out_valid && i_out_ready) begin
                if (expected_words.size() == 0) begin
                    report_mismatch("unexpected word", o_out.out_byte, 8'h00);
                end else begin
                    want = expected_words.pop_front();
                    if (o_out.out_byte !== want.out_byte)
                        report_mismatch("out_byte", o_out.out_byte, want.out_byte);
                    if (o_out.out_last !== want.out_last)
                        report_mismatch("out_last", {7'd0, o_out.out_last},
                                        {7'd0, want.out_last});
                end
            end
            if (stall_cycles >= WatchdogLimit && !run_done) begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    task automatic write_key_reg(input acc_pkg::t_reg_index idx, input logic [63:0] val);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == acc_pkg::REG_KEY_HIGH) cipher_key[127:64] = val;
        else cipher_key[63:0] = val;
    endtask

    task automatic add_byte(input logic [7:0] d, input bit first, input bit last,
                            input logic [63:0] ivh, input logic [63:0] ivl);
        acc_pkg::t_in_word w;
        w.data_byte = d;
        w.first_byte = first;
        w.last_byte = last;
        w.iv_high = ivh;
        w.iv_low = ivl;
        pending_words.push_back(w);
    endtask

    // random message of the given length with a random iv
    task automatic add_message(input int unsigned len);
        logic [63:0] ivh, ivl;
        ivh = {$urandom, $urandom};
        ivl = {$urandom, $urandom};
        if ($urandom_range(0, 7) == 0) ivl = '1;
        if ($urandom_range(0, 15) == 0) ivh = '1;
        for (int i = 0; i < len; i++)
            add_byte(8'($urandom_range(0, 255)), i == 0, i == len - 1,
                     $urandom_range(0, 3) == 0 ? {$urandom, $urandom} : ivh,
                     $urandom_range(0, 3) == 0 ? {$urandom, $urandom} : ivl);
    endtask

    task automatic wait_drained();
        while (pending_words.size() > 0 || expected_words.size() > 0 || i_in_valid)
            @(posedge i_clk);
        repeat (DrainCycles) @(posedge i_clk);
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in = '0;
        i_out_ready = 1'b1;
        i_cfg_we = 1'b0;
        i_cfg_index = acc_pkg::REG_KEY_HIGH;
        i_cfg_data = '0;
        cipher_key = '0;
        counter_value = '0;
        block_pos = 4'd0;
        mismatch_count = 0;
        stall_cycles = 0;
        idle_enable = 1'b0;
        run_done = 1'b0;
        in_taken = 1'b0;
        for (int i = 0; i < 16; i++) keystream[i] = 8'h00;
        build_subst();
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // standard test vector key, then extremes of data and counter wrap
        write_key_reg(acc_pkg::REG_KEY_HIGH, 64'h2b7e151628aed2a6);
        write_key_reg(acc_pkg::REG_KEY_LOW, 64'habf7158809cf4f3c);
        add_byte(8'h00, 1'b1, 1'b0, 64'hf0f1f2f3f4f5f6f7, 64'hf8f9fafbfcfdfeff);
        add_byte(8'hff, 1'b0, 1'b0, 64'h0, 64'h0);
        for (int i = 0; i < 15; i++) add_byte(8'(i * 17), 1'b0, 1'b0, 64'h0, 64'h0);
        add_byte(8'h5a, 1'b0, 1'b1, 64'h0, 64'h0);
        // no first byte after the end of a message
        add_byte(8'h33, 1'b0, 1'b0, '1, '1);
        add_byte(8'hcc, 1'b0, 1'b1, '1, '1);
        // counter wraps from all ones to zero
        add_byte(8'h01, 1'b1, 1'b0, '1, '1);
        for (int i = 0; i < 16; i++) add_byte(8'h80, 1'b0, i == 15, '1, '1);
        add_byte(8'h7f, 1'b1, 1'b1, 64'h0, 64'hffffffffffffffff);
        wait_drained();

        write_key_reg(acc_pkg::REG_KEY_HIGH, '1);
        write_key_reg(acc_pkg::REG_KEY_LOW, '1);
        idle_enable = 1'b1;
        for (int m = 0; m < 20; m++) add_message($urandom_range(1, 40));
        // key change mid-block: block in flight keeps old keystream
        add_byte(8'h11, 1'b1, 1'b0, 64'h0123, 64'h4567);
        add_byte(8'h22, 1'b0, 1'b0, 64'h0, 64'h0);
        wait_drained();
        write_key_reg(acc_pkg::REG_KEY_LOW, 64'h0);
        add_byte(8'h44, 1'b0, 1'b0, 64'h0, 64'h0);
        wait_drained();
        write_key_reg(acc_pkg::REG_KEY_HIGH, 64'h0);
        for (int m = 0; m < 15; m++) add_message($urandom_range(1, 35));
        wait_drained();

        for (int k = 0; k < 2; k++) begin
            write_key_reg(acc_pkg::REG_KEY_HIGH, {$urandom, $urandom});
            write_key_reg(acc_pkg::REG_KEY_LOW, {$urandom, $urandom});
            for (int m = 0; m < 15; m++) begin
                if ($urandom_range(0, 9) == 0)
                    add_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                             1'($urandom_range(0, 1)), {$urandom, $urandom},
                             {$urandom, $urandom});
                else
                    add_message($urandom_range(1, 40));
            end
            wait_drained();
        end

        idle_enable = 1'b0;
        for (int m = 0; m < 10; m++) add_message($urandom_range(1, 30));
        wait_drained();
        run_done = 1'b1;

        if (mismatch_count == 0 && expected_words.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// File: aes128_ctr_stream_cipher_core.f
+incdir+rtl
rtl/acc_pkg.sv
rtl/acc_round_unit.sv
rtl/aes128_ctr_stream_cipher_core.sv
tb/aes128_ctr_stream_cipher_core_test.sv
